[design/modexp_pkg.sv]
`default_nettype none
package modexp_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_BIT,
        S_MUL,
        S_SQR,
        S_OUT
    } t_state;

    localparam int unsigned MODULUS_RESET = 1000000007;

endpackage
`default_nettype wire

[design/modular_exponentiation.sv]
`default_nettype none
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------
// in       | start / busy        | i_base_value, i_exponent
// config   | i_cfg_we            | i_cfg_data (modulus)
// result   | o_valid (strobe)    | o_power_result
//
// Beats are worked one at a time: busy is high from the accepting edge until the strobe.
// A shared bit-serial multiplier does every product: one base
// reduction, then per exponent bit up to the highest set one a decode state, a multiply
// on set bits and a square below the top bit; exponent 0 goes straight to the output.
// Synchronous active-low reset restores modulus 1000000007; the strobe cannot stall.
module modular_exponentiation #(
    parameter int EXPONENT_WIDTH = 63,
    parameter int MODULUS_WIDTH  = 31
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [MODULUS_WIDTH-1:0]  i_base_value,
    input  wire logic [EXPONENT_WIDTH-1:0] i_exponent,
    input  wire logic                      i_cfg_we,
    input  wire logic [MODULUS_WIDTH-1:0]  i_cfg_data,
    output logic                           o_valid,
    output logic [MODULUS_WIDTH-1:0]       o_power_result
);
    import modexp_pkg::*;

    localparam int W = MODULUS_WIDTH;
    localparam int E = EXPONENT_WIDTH;

    t_state       r_state;
    t_state       n_state;
    logic [W-1:0] r_modulus;
    logic [W:0]   mod_wide;     // modulus, zero code widened to 2^W
    logic [E-1:0] r_e;
    logic [W-1:0] r_r;
    logic [W-1:0] r_b;
    logic         r_valid;
    logic [W-1:0] r_out;

    logic         mul_start;
    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic         mul_done;
    logic [W-1:0] mul_prod;
    logic         accept;
    logic         rest_zero;    // no set bits above the current one

    assign accept    = start && (r_state == S_IDLE);
    assign rest_zero = (r_e >> 1) == '0;
    assign mod_wide  = {r_modulus == '0, r_modulus};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= W'(MODULUS_RESET);
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_OUT);
        end
    end

    // Next state and multiplier launch.
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = r_b;
        mul_b     = r_b;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_exponent == '0) begin
                        n_state = S_OUT;
                    end else begin
                        // base * 1 mod m brings the base into range
                        mul_start = 1'b1;
                        mul_a     = i_base_value;
                        mul_b     = W'(1);
                        n_state   = S_RED;
                    end
                end
            end
            S_RED: begin
                if (mul_done) begin
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                mul_start = 1'b1;
                if (r_e[0]) begin
                    mul_a   = r_r;
                    n_state = S_MUL;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    if (rest_zero) begin
                        n_state = S_OUT;
                    end else begin
                        mul_start = 1'b1;
                        n_state   = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (mul_done) begin
                    n_state = S_BIT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e <= i_exponent;
            r_r <= W'(1);
        end
        if (r_state == S_RED && mul_done) begin
            r_b <= mul_prod;
        end
        if (r_state == S_MUL && mul_done) begin
            r_r <= mul_prod;
        end
        if (r_state == S_SQR && mul_done) begin
            r_b <= mul_prod;
            r_e <= r_e >> 1;
        end
        if (r_state == S_OUT) begin
            r_out <= r_r;
        end
    end

    // MUL in S_MUL needs b in range; mul_b follows the base register except in the reduction, where it is 1
    modexp_mul #(
        .W(W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_mod   (mod_wide),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_power_result = r_out;
endmodule
`default_nettype wire

[design/modexp_mul.sv]
`default_nettype none
// Bit-serial interleaved modular multiply: one multiplier bit per cycle, MSB first.
// Requires i_b < modulus and acc kept below modulus.
module modexp_mul #(
    parameter int W = 31
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W:0]   i_mod,
    output logic              o_done,
    output logic [W-1:0]      o_prod
);
    localparam int CW = $clog2(W);

    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W:0]    r_m;
    logic [W:0]    r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W+1:0]  sum;
    logic [W+1:0]  m1;
    logic [W+1:0]  m2;
    logic [W+1:0]  red;

    always_comb begin
        sum = {r_acc, 1'b0} + (r_a[W-1] ? {2'b00, r_b} : '0);
        m1  = {1'b0, r_m};
        m2  = {r_m, 1'b0};
        if (sum >= m2) begin
            red = sum - m2;
        end else if (sum >= m1) begin
            red = sum - m1;
        end else begin
            red = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_mod;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= r_a << 1;
            r_acc <= red[W:0];
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc[W-1:0];
endmodule
`default_nettype wire

[design/modexp_chk.sv]
`default_nettype none
module modexp_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_busy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && $past(busy) && $past(i_rst_n)) |-> o_valid)
        else $error("busy dropped without a result");
endmodule

bind modular_exponentiation modexp_chk u_modexp_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
`default_nettype wire

[tb/sv/modular_exponentiation_tb.sv]
`timescale 1ns / 1ps
module modular_exponentiation_tb;
    import modexp_pkg::*;

    localparam int EXP_W = 63;
    localparam int MOD_W = 31;

    typedef struct {
        logic [MOD_W-1:0] base_value;
        logic [EXP_W-1:0] exponent;
    } power_req_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [MOD_W-1:0] i_base_value = '0;
    logic [EXP_W-1:0] i_exponent = '0;
    logic             i_cfg_we = 1'b0;
    logic [MOD_W-1:0] i_cfg_data = '0;
    logic             o_valid;
    logic [MOD_W-1:0] o_power_result;

    power_req_t       req_queue[$];     // beats waiting to be offered
    logic [MOD_W-1:0] power_expected[$]; // predicted results, oldest first
    logic [MOD_W-1:0] modulus_copy = MOD_W'(MODULUS_RESET);
    int unsigned      send_idle_pct = 0;
    bit               failed = 1'b0;

    modular_exponentiation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_base_value  (i_base_value),
        .i_exponent    (i_exponent),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_power_result(o_power_result)
    );

    always #1 i_clk = ~i_clk;

    // Modulus 0 stands for 2^31, i.e. keep the low 31 bits.
    function automatic logic [63:0] mod_reduce(logic [63:0] v, logic [MOD_W-1:0] m);
        if (m == 0) begin
            return v & {33'd0, {MOD_W{1'b1}}};
        end
        return v % {33'd0, m};
    endfunction

    // Right-to-left square and multiply; exponent zero gives 1 unreduced.
    function automatic logic [MOD_W-1:0] predict_power(power_req_t r, logic [MOD_W-1:0] m);
        logic [63:0]      b;
        logic [63:0]      acc;
        logic [EXP_W-1:0] e;
        b   = {33'd0, r.base_value};
        acc = 64'd1;
        e   = r.exponent;
        while (e != 0) begin
            if (e[0]) begin
                acc = mod_reduce(acc * b, m);
            end
            b = mod_reduce(b * b, m);
            e = e >> 1;
        end
        return acc[MOD_W-1:0];
    endfunction

    // Driver: offer the head of the queue at the falling edge, with random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            start        <= 1'b1;
            i_base_value <= req_queue[0].base_value;
            i_exponent   <= req_queue[0].exponent;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: register writes, accepted beats and result strobes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                modulus_copy <= i_cfg_data;
            end
            if (start && !busy) begin
                power_expected = {power_expected, predict_power(req_queue[0], modulus_copy)};
                void'(req_queue.pop_front());
            end
            if (o_valid) begin
                if (power_expected.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %0d",
                             $time, o_power_result);
                    failed = 1'b1;
                end else begin
                    if (o_power_result !== power_expected[0]) begin
                        $display("%0t: power_result mismatch: expected %0d, actual %0d",
                                 $time, power_expected[0], o_power_result);
                        failed = 1'b1;
                    end
                    void'(power_expected.pop_front());
                end
            end
        end
    end

    task automatic push_req(logic [MOD_W-1:0] b, logic [EXP_W-1:0] e);
        power_req_t r;
        r.base_value = b;
        r.exponent   = e;
        req_queue    = {req_queue, r};
    endtask

    // Hold until every beat is taken and every result checked.
    task automatic drain();
        do @(negedge i_clk);
        while (req_queue.size() != 0 || power_expected.size() != 0 || start);
    endtask

    task automatic write_modulus(logic [MOD_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly short exponents keep the run short; a few use all 63 bits.
    task automatic push_random();
        logic [MOD_W-1:0] b;
        logic [EXP_W-1:0] e;
        int unsigned      len;
        b = MOD_W'($urandom);
        case ($urandom_range(7))
            0: b = '0;
            1: b = MOD_W'(1);
            2: b = '1;
            3: b = modulus_copy - 1'b1;
            default: ;
        endcase
        e = EXP_W'({$urandom, $urandom});
        if ($urandom_range(19) != 0) begin
            len = $urandom_range(8);
            e   = e & ((EXP_W'(1) << len) - 1'b1);
        end
        push_req(b, e);
    endtask

    initial begin
        logic [MOD_W-1:0] mods[10];
        mods = '{'1, MOD_W'(2), '0, MOD_W'(1), MOD_W'(3), MOD_W'(65537),
                 MOD_W'(12345678), MOD_W'(2147483629), MOD_W'(97), MOD_W'(1000)};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset modulus.
        push_req('0, '0);
        push_req('1, '0);
        push_req('0, EXP_W'(1));
        push_req('1, EXP_W'(1));
        push_req('1, '1);
        push_req(MOD_W'(2), EXP_W'(62));
        push_req(MOD_W'(MODULUS_RESET), EXP_W'(5));      // base equal to modulus
        push_req(MOD_W'(MODULUS_RESET + 3), EXP_W'(7));  // base above modulus
        push_req(MOD_W'(1), '1);
        push_req(MOD_W'(3), EXP_W'(MODULUS_RESET - 1));  // Fermat, gives 1
        push_req(MOD_W'(12345), {1'b1, 62'd0});
        push_req('1, {31'd0, 32'hFFFF_FFFF});
        drain();

        for (int p = 0; p < 10; p++) begin
            send_idle_pct = (p < 4) ? 34 : (p < 7) ? 63 : 0;
            write_modulus(mods[p]);
            @(negedge i_clk);
            push_req('1, '1);
            push_req(MOD_W'(2), '0);
            for (int n = 0; n < 183; n++) begin
                push_random();
            end
            drain();
        end

        repeat (50) @(negedge i_clk);
        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
